// ----- rtl/dnf_pkg.sv -----
// ----------------------------------------------------------------------------
// dnf_pkg: shared types and constants of the decimal number glyph formatter
// Glyph codes, the 3-column font, the configuration group and the queue entry
// that the front part hands to the back part.
// ----------------------------------------------------------------------------
package dnf_pkg;

  // Glyph codes: digits use their own value.
  typedef logic [3:0] glyph_t;

  localparam glyph_t GLYPH_MINUS = 4'd10;
  localparam glyph_t GLYPH_POINT = 4'd11;
  localparam glyph_t GLYPH_PLUS  = 4'd12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIELD_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_DECIMAL_PLACES = 2'd1;
  localparam logic [1:0] CFG_SHOW_PLUS      = 2'd2;

  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned MAX_CHARS   = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Reciprocal of 10 for 16-bit operands: q = (x * 52429) >> 19.
  localparam logic [15:0] RECIP10       = 16'd52429;
  localparam int unsigned RECIP10_SHIFT = 19;

  typedef struct packed {
    logic [2:0] field_length;
    logic [1:0] decimal_places;
    logic       show_plus;
  } cfg_t;

  // One formatted number: chars[nchar-1] is sent first, chars[0] last.
  typedef struct packed {
    glyph_t [MAX_CHARS-1:0] chars;
    logic [2:0]             nchar;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qpush_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_WALK,
    FS_PUSH
  } front_state_t;

  // Font lookup; column 3 is the blank spacer column.
  function automatic logic [7:0] glyph_col(input glyph_t code, input logic [1:0] col);
    logic [23:0] row;
    case (code)
      4'd0:        row = {8'h7c, 8'h42, 8'h7c};
      4'd1:        row = {8'h40, 8'h7e, 8'h44};
      4'd2:        row = {8'h4c, 8'h52, 8'h64};
      4'd3:        row = {8'h34, 8'h4a, 8'h4a};
      4'd4:        row = {8'h7e, 8'h24, 8'h38};
      4'd5:        row = {8'h32, 8'h4a, 8'h4e};
      4'd6:        row = {8'h32, 8'h4a, 8'h3c};
      4'd7:        row = {8'h06, 8'h1a, 8'h62};
      4'd8:        row = {8'h76, 8'h4a, 8'h76};
      4'd9:        row = {8'h3c, 8'h52, 8'h4c};
      GLYPH_MINUS: row = {8'h10, 8'h10, 8'h10};
      GLYPH_POINT: row = {8'h00, 8'h60, 8'h60};
      GLYPH_PLUS:  row = {8'h10, 8'h38, 8'h10};
      default:     row = {8'h7c, 8'h42, 8'h7c};
    endcase
    case (col)
      2'd0:    glyph_col = row[7:0];
      2'd1:    glyph_col = row[15:8];
      2'd2:    glyph_col = row[23:16];
      default: glyph_col = 8'h00;
    endcase
  endfunction

endpackage

// ----- rtl/dnf_front.sv -----
// ----------------------------------------------------------------------------
// dnf_front: number intake and character list builder
// Accepts a value, splits its magnitude into five digits by repeated
// division by ten, then walks the digits to build the character list.
// ----------------------------------------------------------------------------
module dnf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dnf_pkg::cfg_t        cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic signed [15:0]   in_tdata,
  output dnf_pkg::qpush_t      push,
  input  logic                 push_ready
);
  import dnf_pkg::*;

  front_state_t              state_r, state_nxt;
  logic [15:0]               mag_r, mag_nxt;
  glyph_t [NUM_DIGITS-1:0]   dig_r, dig_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      nz_r, nz_nxt;
  glyph_t [MAX_CHARS-1:0]    list_r, list_nxt;
  logic [2:0]                nchar_r, nchar_nxt;

  // divide step
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] diff;
  assign prod = {16'd0, mag_r} * {16'd0, RECIP10};
  assign quot = prod[31:RECIP10_SHIFT];
  assign diff = mag_r - ({quot, 3'b000} + {2'b00, quot, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    dig_r   <= dig_nxt;
    cnt_r   <= cnt_nxt;
    nz_r    <= nz_nxt;
    list_r  <= list_nxt;
    nchar_r <= nchar_nxt;
  end

  always_comb begin
    logic [15:0] raw;
    logic        neg;
    logic [1:0]  places;
    logic [2:0]  endi;
    logic [2:0]  width;
    logic [2:0]  first;
    logic        intg;
    glyph_t      d;

    raw    = in_tdata;
    neg    = raw[15];
    places = (cfg.decimal_places == 2'd3) ? 2'd2 : cfg.decimal_places;
    endi   = 3'd5 - {1'b0, places};
    width  = (cfg.field_length > 3'd5) ? 3'd5 : cfg.field_length;
    first  = 3'd5 - width;
    d      = dig_r[0];
    intg   = 1'b0;

    state_nxt = state_r;
    mag_nxt   = mag_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    nz_nxt    = nz_r;
    list_nxt  = list_r;
    nchar_nxt = nchar_r;

    in_tready        = 1'b0;
    push.valid       = 1'b0;
    push.entry.chars = list_r;
    push.entry.nchar = nchar_r;

    case (state_r)
      FS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mag_nxt     = neg ? (~raw + 16'd1) : raw;
          list_nxt    = '0;
          list_nxt[0] = neg ? GLYPH_MINUS : GLYPH_PLUS;
          nchar_nxt   = {2'b00, (neg | cfg.show_plus)};
          cnt_nxt     = 3'd0;
          nz_nxt      = 1'b0;
          state_nxt   = FS_DIV;
        end
      end
      FS_DIV: begin
        // least significant digit first; it ends up at the top
        dig_nxt = {dig_r[NUM_DIGITS-2:0], diff[3:0]};
        mag_nxt = {3'b000, quot};
        if (cnt_r == 3'(NUM_DIGITS - 1)) begin
          cnt_nxt   = 3'd0;
          state_nxt = FS_WALK;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      FS_WALK: begin
        // most significant digit sits at index 0
        if (cfg.field_length == 3'd0) begin
          intg = nz_r || (d != 4'd0) || (cnt_r == 3'(NUM_DIGITS - 1));
        end else begin
          intg = (cnt_r >= first);
        end
        if (cnt_r == endi) begin
          list_nxt  = {list_r[MAX_CHARS-3:0], GLYPH_POINT, d};
          nchar_nxt = nchar_r + 3'd2;
        end else if ((cnt_r > endi) || intg) begin
          list_nxt  = {list_r[MAX_CHARS-2:0], d};
          nchar_nxt = nchar_r + 3'd1;
        end
        nz_nxt  = nz_r || (d != 4'd0);
        dig_nxt = {4'd0, dig_r[NUM_DIGITS-1:1]};
        if (cnt_r == 3'(NUM_DIGITS - 1)) begin
          state_nxt = FS_PUSH;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      FS_PUSH: begin
        push.valid = 1'b1;
        if (push_ready) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dnf_queue.sv -----
// ----------------------------------------------------------------------------
// dnf_queue: short queue of formatted numbers
// Decouples the character list builder from the column sender.
// ----------------------------------------------------------------------------
module dnf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  dnf_pkg::qpush_t  push,
  output logic             push_ready,
  output logic             pop_valid,
  output dnf_pkg::entry_t  pop_entry,
  input  logic             pop
);
  import dnf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ----- rtl/dnf_back.sv -----
// ----------------------------------------------------------------------------
// dnf_back: glyph column sender
// Takes one character list from the queue and sends four column beats per
// character through a registered output stage.
// ----------------------------------------------------------------------------
module dnf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  dnf_pkg::entry_t  pop_entry,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);
  import dnf_pkg::*;

  glyph_t [MAX_CHARS-1:0] chars_r, chars_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic [1:0]             col_r, col_nxt;
  logic                   busy_r, busy_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [7:0]             odata_r, odata_nxt;
  logic                   olast_r, olast_nxt;
  logic                   slot_free;

  assign slot_free  = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_comb begin
    chars_nxt  = chars_r;
    idx_nxt    = idx_r;
    col_nxt    = col_r;
    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    if (!busy_r) begin
      if (pop_valid) begin
        pop       = 1'b1;
        chars_nxt = pop_entry.chars;
        idx_nxt   = pop_entry.nchar - 3'd1;
        col_nxt   = 2'd0;
        busy_nxt  = 1'b1;
      end
    end else if (slot_free) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = glyph_col(chars_r[idx_r], col_r);
      olast_nxt  = (idx_r == 3'd0) && (col_r == 2'd3);
      col_nxt    = col_r + 2'd1;
      if (col_r == 2'd3) begin
        if (idx_r == 3'd0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    idx_r   <= idx_nxt;
    col_r   <= col_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// ----- rtl/decimal_number_glyph_formatter.sv -----
// ----------------------------------------------------------------------------
// decimal_number_glyph_formatter: signed value to LCD font columns
// Draws a signed 16-bit value as decimal text in a 3-column font, one
// 8-pixel column byte per output beat.
// ----------------------------------------------------------------------------
// Each accepted value produces 4 to 28 column beats: four per character
// (three font columns and a blank spacer), for an optional sign, the integer
// digits, and, when decimal_places is nonzero, a point and that many fraction
// digits (3 counts as 2). out_tlast marks the final beat of each value. The
// front part accepts a value, runs five divide-by-ten steps and a five-step
// digit walk, then hands off to the queue; the back part takes a load step
// per value, then sends one beat per cycle while out_tready allows. The
// sustained rate is set by the slower part: the front part for one- and
// two-character values, the column sender for longer ones. A two-entry queue
// lets the front part format the next value while columns of the previous
// ones still drain. Write configuration only while no value is in flight.
// ----------------------------------------------------------------------------
module decimal_number_glyph_formatter (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [2:0]         cfg_wdata,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [15:0] in_tdata,   // [15:0] number_value
  // output stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [7:0] column_byte
  output logic               out_tlast   // last_column
);
  import dnf_pkg::*;

  cfg_t    cfg_r;
  qpush_t  push;
  logic    push_ready;
  logic    pop_valid;
  entry_t  pop_entry;
  logic    pop;

  // Hold the configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FIELD_LENGTH:   cfg_r.field_length   <= cfg_wdata;
        CFG_DECIMAL_PLACES: cfg_r.decimal_places <= cfg_wdata[1:0];
        CFG_SHOW_PLUS:      cfg_r.show_plus      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: split into digits and build the character list.
  dnf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_ready (push_ready)
  );

  // Queue between the two halves.
  dnf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  // Back: advance through characters and font columns.
  dnf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- bench/decimal_number_glyph_formatter_tb.sv -----
// ----------------------------------------------------------------------------
// decimal_number_glyph_formatter_tb: self-checking bench for the glyph formatter
// Streams signed values through the formatter under a series of register
// settings and checks every column beat, and its last flag, against a
// behavioral model of the font, the sign, the width and the decimal point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_number_glyph_formatter_tb;
  import dnf_pkg::*;

  // One expected output beat: a font column and its end-of-number flag.
  typedef struct {
    logic [7:0] column;
    logic       last;
  } column_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_addr = '0;
  logic [2:0]         cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic signed [15:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  decimal_number_glyph_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Bench copy of the register file, updated once a write sequence completes.
  logic [2:0] field_length_r   = '0;
  logic [1:0] decimal_places_r = '0;
  logic       show_plus_r      = 1'b0;

  logic signed [15:0] pending_values[$];   // values waiting to go out on the input
  column_beat_t       expected_columns[$]; // columns the formatter still owes us

  int n_queued     = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_numbers    = 0;
  int n_settings   = 0;
  int error_count  = 0;

  // Sender and receiver pacing; the calm flags give stretches with no idling.
  bit tx_calm    = 1'b0;
  bit rx_calm    = 1'b0;
  int burst_left = 1;
  int gap_left   = 0;
  int stall_left = 0;
  int acc_mark   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Font and formatting model
  // --------------------------------------------------------------------------

  // Three font columns of one glyph, first column in the top byte.
  function automatic logic [23:0] glyph_columns(input int unsigned code);
    logic [23:0] bits;
    case (code)
      0:           bits = 24'h7c427c;
      1:           bits = 24'h447e40;
      2:           bits = 24'h64524c;
      3:           bits = 24'h4a4a34;
      4:           bits = 24'h38247e;
      5:           bits = 24'h4e4a32;
      6:           bits = 24'h3c4a32;
      7:           bits = 24'h621a06;
      8:           bits = 24'h764a76;
      9:           bits = 24'h4c523c;
      GLYPH_MINUS: bits = 24'h101010;
      GLYPH_POINT: bits = 24'h606000;
      GLYPH_PLUS:  bits = 24'h103810;
      default:     bits = 24'h7c427c;
    endcase
    return bits;
  endfunction

  // Work out the text for one value under the current settings and queue its
  // column beats.
  task automatic predict_columns(input logic signed [15:0] value);
    logic [16:0]  mag;
    int unsigned  rest;
    int unsigned  digit[5];
    int unsigned  text[$];
    int           places;
    int           lead;
    int           i;
    int           c;
    logic [23:0]  bits;
    column_beat_t beat;
    // magnitude on 17 bits so the most negative value keeps its 32768
    mag = value[15] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
    rest = mag;
    for (i = 4; i >= 0; i--) begin
      digit[i] = rest % 10;
      rest = rest / 10;
    end
    places = (decimal_places_r > 2) ? 2 : int'(decimal_places_r);

    if (value[15]) begin
      text.push_back(GLYPH_MINUS);
    end else if (show_plus_r) begin
      text.push_back(GLYPH_PLUS);
    end

    // automatic width skips leading zeros but always keeps the units digit;
    // oversized field lengths clamp to all five digits
    if (field_length_r == 0) begin
      lead = 0;
      while (lead < 4 && digit[lead] == 0) lead++;
    end else begin
      lead = 5 - ((field_length_r > 5) ? 5 : int'(field_length_r));
    end

    // the integer run may be empty when it would start inside the fraction
    for (i = lead; i < 5 - places; i++) text.push_back(digit[i]);

    if (places >= 1) begin
      text.push_back(GLYPH_POINT);
      if (places == 2) text.push_back(digit[3]);
      text.push_back(digit[4]);
    end

    for (i = 0; i < text.size(); i++) begin
      bits = glyph_columns(text[i]);
      for (c = 0; c < 4; c++) begin
        beat.column = (c < 3) ? bits[23 - 8*c -: 8] : 8'h00;
        beat.last   = (i == text.size() - 1) && (c == 3);
        expected_columns.push_back(beat);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input side: sample accepted beats at the rising edge, drive at the falling
  // --------------------------------------------------------------------------

  // Predict as each value is taken, using the settings in force right now.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_columns(in_tdata);
      void'(pending_values.pop_front());
      n_accepted++;
    end
  end

  // Hold a value until it is taken; otherwise present the next one, working
  // in bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && n_accepted == acc_mark) begin
      // hold the current beat
    end else begin
      acc_mark = n_accepted;
      if (gap_left > 0 && !tx_calm) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_values.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_values[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: stall in random runs, check each accepted column beat
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n || rx_calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    column_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_columns.size() == 0) begin
        report_mismatch($sformatf("unexpected column beat %02h last=%0b",
                                  out_tdata, out_tlast));
      end else begin
        want = expected_columns.pop_front();
        if (out_tdata !== want.column)
          report_mismatch($sformatf("column_byte %02h, want %02h (beat %0d)",
                                    out_tdata, want.column, n_checked));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_column %0b, want %0b (beat %0d)",
                                    out_tlast, want.last, n_checked));
        if (want.last) n_numbers++;
      end
      n_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_value(input logic signed [15:0] value);
    pending_values.push_back(value);
    n_queued++;
  endtask

  // Sender pause: nothing queued, nothing in flight, every column back.
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_columns.size() != 0) @(negedge clk);
  endtask

  // Drain, then write all three registers on consecutive cycles.
  task automatic set_format(input logic [2:0] width, input logic [1:0] places,
                            input logic plus);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FIELD_LENGTH;
    cfg_wdata <= width;
    @(negedge clk);
    cfg_addr  <= CFG_DECIMAL_PLACES;
    cfg_wdata <= {1'b0, places};
    @(negedge clk);
    cfg_addr  <= CFG_SHOW_PLUS;
    cfg_wdata <= {2'b00, plus};
    @(negedge clk);
    cfg_we    <= 1'b0;
    field_length_r   = width;
    decimal_places_r = places;
    show_plus_r      = plus;
    n_settings++;
  endtask

  // Mix of full-range words, small values and large magnitudes of both signs.
  function automatic logic signed [15:0] random_value();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 99));
      2:       return -16'sd1 * 16'($urandom_range(0, 999));
      3:       return 16'($urandom_range(10000, 32767));
      default: return 16'($urandom_range(32768, 65535));
    endcase
  endfunction

  initial begin
    int phase;
    int k;
    int count;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Automatic width, no fraction, no plus: extremes and the zero case.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_format(3'd0, 2'd0, 1'b0);
    queue_value(16'sd0);
    queue_value(16'sd1);
    queue_value(-16'sd1);
    queue_value(16'sd32767);
    queue_value(-16'sd32767);
    queue_value(16'sh8000);       // most negative value
    queue_value(16'sd12345);
    queue_value(16'sd100);

    // Full fixed width, two places, plus sign, with idling on both sides.
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    set_format(3'd5, 2'd2, 1'b1);
    queue_value(16'sd0);
    queue_value(16'sd5);
    queue_value(-16'sd5);
    queue_value(16'sd32767);
    queue_value(16'sh8000);

    // Automatic width with two places: digits swallowed by the fraction.
    set_format(3'd0, 2'd2, 1'b1);
    queue_value(16'sd5);
    queue_value(16'sd0);
    queue_value(-16'sd7);
    queue_value(16'sd99);

    // Oversized field length and decimal places clamp to 5 and 2.
    set_format(3'd7, 2'd3, 1'b0);
    queue_value(16'sd12345);
    queue_value(-16'sd1);
    set_format(3'd6, 2'd1, 1'b0);
    queue_value(-16'sd32767);

    // Narrow field truncates wide values.
    set_format(3'd1, 2'd1, 1'b1);
    queue_value(16'sd12345);
    queue_value(16'sd0);
    queue_value(-16'sd98);

    // Random settings, each phase a batch of random values.
    for (phase = 0; phase < 10; phase++) begin
      set_format(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      count = $urandom_range(16, 26);
      for (k = 0; k < count; k++) queue_value(random_value());
    end

    // Leave the registers at their reset values and push a last batch.
    set_format(3'd0, 2'd0, 1'b0);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    for (k = 0; k < 15; k++) queue_value(random_value());

    wait_drained();
    // let any stray beat surface before judging
    repeat (40) @(negedge clk);

    $display("Sent %0d values under %0d register settings.", n_queued, n_settings);
    $display("Checked %0d column beats closing %0d numbers.", n_checked, n_numbers);
    if (error_count == 0 && expected_columns.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d column beats never arrived.",
               error_count, expected_columns.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d values sent, %0d column beats outstanding.",
             n_accepted, expected_columns.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
